### rtl/core/ffha_pkg.sv
`default_nettype none
package ffha_pkg;
  localparam int unsigned MAX_BLOCKS_DEF   = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam int unsigned ALIGN_BYTES_DEF  = 16;
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned REQ_W  = 32;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 1'd1;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_size;
    logic [47:0] pointer_in;
  } req_t;

  typedef struct packed {
    logic [47:0] address;
    logic [1:0]  status;
  } rsp_t;

  // One table entry: offset, payload bytes, free mark.
  typedef struct packed {
    logic [20:0] offset;
    logic [20:0] bytes;
    logic        free;
  } entry_t;
endpackage
`default_nettype wire

### rtl/core/ffha_if.sv
`default_nettype none
interface ffha_req_if;
  import ffha_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffha_rsp_if;
  import ffha_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/first_fit_heap_allocator_unit.sv
// First-fit heap allocator with split and coalesce.
// Requests arrive on req (opcode, request_size, pointer_in); each gives one
// item on rsp (address, status). The block table sits in one synchronous
// memory of MAX_BLOCKS entries, read through a registered output.
// An allocate walks the table from entry 0, reading each entry in S_RD and
// checking it in S_CHK, until the first free block that fits; a split then
// shifts the tail up one entry per cycle and inserts the new free block. A
// free walks to the matching entry, checks both neighbors, then a merge
// shifts the tail down one entry per cycle. One item is in work at a time,
// so the next item is taken only after the result leaves.
// The result sits in an output register; req stays low until it is taken, so
// a stalled receiver simply holds the block.
// Reset, or a write of heap_base or heap_size, makes the table one free
// block; entry 0 is rewritten once the unit is idle, and req stays low until then.
// No clearing pass is needed since only entries below block_count are read.
`default_nettype none
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ffha_req_if.sink                  req,
  ffha_rsp_if.source                rsp
);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HDR_A = ADDR_W'(HEADER_BYTES);
  localparam logic [33:0] ALN = 34'(ALIGN_BYTES);
  localparam logic [33:0] HDR_MIN = 34'(HEADER_BYTES + 16);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2, S_SPL = 4'd3,
                         S_INS = 4'd4, S_UPW = 4'd5, S_FRN = 4'd6, S_FRNC = 4'd7,
                         S_FRP = 4'd8, S_FRPC = 4'd9, S_DNW = 4'd11,
                         S_FIN = 4'd12, S_OUT = 4'd13;

  logic [3:0] state;
  logic [ADDR_W-1:0] heap_base;
  logic [SIZE_W-1:0] heap_size;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;      // walk position
  logic [CW-1:0] hit;      // chosen entry
  logic [CW-1:0] del;      // first entry to remove
  logic [1:0]    ndel;     // number of entries to remove
  logic        op;
  logic [33:0] need;
  logic [ADDR_W-1:0] ptr;
  entry_t cur, newe;
  rsp_t out;
  logic out_valid;

  entry_t mem [MAX_BLOCKS];
  entry_t rd;
  logic          we;
  logic [IW-1:0] wa, ra;
  entry_t        wd;
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

  logic [CW-1:0] ra_w;
  assign ra = ra_w[IW-1:0];

  logic [33:0] req_up;
  assign req_up = (34'(req.data.request_size) + ALN - 34'd1) / ALN * ALN;

  logic [ADDR_W-1:0] pay;
  assign pay = heap_base + ADDR_W'(rd.offset) + HDR_A;

  entry_t init_e;
  assign init_e.offset = '0;
  assign init_e.bytes  = (heap_size >= HDR) ? heap_size - HDR : '0;
  assign init_e.free   = 1'b1;

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_index == REG_HEAP_BASE || cfg_index == REG_HEAP_SIZE);
  logic init_pend;

  assign req.ready = (state == S_IDLE) && !out_valid && !init_pend;
  assign rsp.valid = out_valid;
  assign rsp.data  = out;

  always_comb begin
    we = 1'b0; wa = '0; wd = rd; ra_w = idx;
    unique case (state)
      S_IDLE: begin
        we = init_pend; wa = '0; wd = init_e;
      end
      S_SPL: begin
        we = 1'b1; wa = hit[IW-1:0]; wd = cur;
        ra_w = count - CW'(1);
      end
      S_UPW: begin
        we = 1'b1; wa = IW'(idx + CW'(1)); wd = rd;
        ra_w = idx - CW'(1);
      end
      S_INS: begin
        we = 1'b1; wa = IW'(hit + CW'(1)); wd = newe;
      end
      S_FRN: ra_w = hit + CW'(1);
      S_FRP: ra_w = hit - CW'(1);
      S_FIN: begin
        we = 1'b1; wa = hit[IW-1:0]; wd = cur;
        ra_w = del + CW'(ndel);
      end
      S_DNW: begin
        we = 1'b1; wa = IW'(idx - CW'(ndel)); wd = rd;
        ra_w = idx + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; heap_base <= '0; heap_size <= SIZE_W'(65536);
      count <= CW'(1); out_valid <= 1'b0; init_pend <= 1'b1;
    end else begin
      if (cfg_hit) begin
        if (cfg_index == REG_HEAP_BASE) heap_base <= cfg_data[ADDR_W-1:0];
        else heap_size <= cfg_data[SIZE_W-1:0];
        count <= CW'(1); init_pend <= 1'b1;
      end else if (state == S_IDLE && init_pend) begin
        init_pend <= 1'b0;
      end
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          op <= req.data.opcode; ptr <= req.data.pointer_in;
          need <= req_up; idx <= '0; del <= '0; ndel <= '0;
          out.address <= '0;
          if (req.data.opcode == OP_ALLOC) begin
            out.status <= ST_NOFIT;
            state <= (req_up == 34'd0) ? S_OUT : S_RD;
          end else begin
            out.status <= (req.data.pointer_in == '0) ? ST_NULL : ST_UNKNOWN;
            state <= (req.data.pointer_in == '0) ? S_OUT : S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          hit <= idx;
          cur.offset <= rd.offset;
          if (op == OP_ALLOC) begin
            if (rd.free && 34'(rd.bytes) >= need) begin
              out.status <= ST_OK; out.address <= pay;
              cur.free <= 1'b0;
              if (count < CNT_MAX && 34'(rd.bytes) >= need + HDR_MIN) begin
                cur.bytes <= need[SIZE_W-1:0];
                newe.offset <= rd.offset + HDR + need[SIZE_W-1:0];
                newe.bytes <= rd.bytes - need[SIZE_W-1:0] - HDR;
                newe.free <= 1'b1;
                state <= S_SPL;
              end else begin
                cur.bytes <= rd.bytes;
                state <= S_FIN;
              end
            end else begin
              cur.free <= rd.free; cur.bytes <= rd.bytes;
              if (idx + CW'(1) >= count) state <= S_OUT;
              else begin idx <= idx + CW'(1); state <= S_RD; end
            end
          end else begin
            cur.bytes <= rd.bytes;
            if (pay == ptr) begin
              out.status <= ST_OK;
              cur.free <= 1'b1;
              if (rd.free) state <= S_OUT;
              else if (idx + CW'(1) < count) state <= S_FRN;
              else if (idx != '0) state <= S_FRP;
              else state <= S_FIN;
            end else begin
              cur.free <= rd.free;
              if (idx + CW'(1) >= count) state <= S_OUT;
              else begin idx <= idx + CW'(1); state <= S_RD; end
            end
          end
        end
        // shift entries hit+1..count-1 up by one, from the top
        S_SPL: begin
          idx <= count - CW'(1);
          state <= (count - CW'(1) > hit) ? S_UPW : S_INS;
        end
        S_UPW: begin
          if (idx - CW'(1) > hit) idx <= idx - CW'(1);
          else state <= S_INS;
        end
        S_INS: begin
          count <= count + CW'(1); state <= S_OUT;
        end
        S_FRN: state <= S_FRNC;
        S_FRNC: begin
          if (rd.free) begin
            cur.bytes <= cur.bytes + HDR + rd.bytes;
            del <= hit + CW'(1); ndel <= 2'd1;
          end
          state <= (hit != '0) ? S_FRP : S_FIN;
        end
        S_FRP: state <= S_FRPC;
        S_FRPC: begin
          if (rd.free) begin
            // previous absorbs current (and any next already folded in)
            cur.offset <= rd.offset;
            cur.bytes <= rd.bytes + HDR + cur.bytes;
            hit <= hit - CW'(1);
            del <= hit; ndel <= ndel + 2'd1;
          end
          state <= S_FIN;
        end
        // write back the chosen entry, then close the gap left by a merge
        S_FIN: begin
          if (ndel == '0) state <= S_OUT;
          else if (del + CW'(ndel) < count) begin
            idx <= del + CW'(ndel); state <= S_DNW;
          end else begin
            count <= count - CW'(ndel); state <= S_OUT;
          end
        end
        S_DNW: begin
          if (idx + CW'(1) < count) idx <= idx + CW'(1);
          else begin
            count <= count - CW'(ndel); state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_ready_idle;
    @(posedge clk) disable iff (rst) req.ready |-> (state == S_IDLE);
  endproperty
  assert property (p_ready_idle) else $error("ready outside idle");
  property p_count;
    @(posedge clk) disable iff (rst) (count != '0) && (count <= CNT_MAX);
  endproperty
  assert property (p_count) else $error("block count out of range");
  property p_out;
    @(posedge clk) disable iff (rst) (state == S_OUT) |=> out_valid;
  endproperty
  assert property (p_out) else $error("result lost");
endmodule
`default_nettype wire

### verif/ffha_checker.sv
module ffha_checker
  import ffha_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ffha_req_if                       req,
  ffha_rsp_if                       rsp,
  output int                        fail_count,
  output int                        pending
);
  localparam int unsigned TABLE_DEPTH = MAX_BLOCKS_DEF;
  localparam int unsigned HDR = HEADER_BYTES_DEF;
  localparam int unsigned ALIGN = ALIGN_BYTES_DEF;
  localparam int unsigned MIN_TAIL = 16;

  logic [ADDR_W-1:0] arena_base;
  logic [SIZE_W-1:0] arena_size;
  logic [SIZE_W-1:0] blk_off   [TABLE_DEPTH];
  logic [SIZE_W-1:0] blk_len   [TABLE_DEPTH];
  bit                blk_avail [TABLE_DEPTH];
  int                blk_cnt;
  rsp_t              expected_rsp[$];

  function automatic void table_clear();
    blk_off[0] = '0;
    blk_len[0] = (arena_size >= HDR) ? arena_size - SIZE_W'(HDR) : '0;
    blk_avail[0] = 1'b1;
    blk_cnt = 1;
  endfunction

  function automatic logic [ADDR_W-1:0] payload_addr(int idx);
    return arena_base + ADDR_W'(blk_off[idx]) + ADDR_W'(HDR);
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k < blk_cnt - 1; k++) begin
      blk_off[k] = blk_off[k + 1];
      blk_len[k] = blk_len[k + 1];
      blk_avail[k] = blk_avail[k + 1];
    end
    blk_cnt--;
  endfunction

  function automatic rsp_t heap_op(req_t item);
    rsp_t res;
    longint unsigned need;
    longint unsigned have;
    res.address = '0;
    res.status = ST_NOFIT;
    if (item.opcode == OP_ALLOC) begin
      need = ((longint'(item.request_size) + ALIGN - 1) / ALIGN) * ALIGN;
      if (need != 0) begin
        for (int i = 0; i < blk_cnt; i++) begin
          have = blk_len[i];
          if (!blk_avail[i] || have < need) continue;
          if (blk_cnt < TABLE_DEPTH && have >= need + HDR + MIN_TAIL) begin
            for (int k = blk_cnt - 1; k > i; k--) begin
              blk_off[k + 1] = blk_off[k];
              blk_len[k + 1] = blk_len[k];
              blk_avail[k + 1] = blk_avail[k];
            end
            blk_off[i + 1] = blk_off[i] + SIZE_W'(HDR) + SIZE_W'(need);
            blk_len[i + 1] = SIZE_W'(have - need - HDR);
            blk_avail[i + 1] = 1'b1;
            blk_len[i] = SIZE_W'(need);
            blk_cnt++;
          end
          blk_avail[i] = 1'b0;
          res.address = payload_addr(i);
          res.status = ST_OK;
          break;
        end
      end
    end else if (item.pointer_in == '0) begin
      res.status = ST_NULL;
    end else begin
      res.status = ST_UNKNOWN;
      for (int i = 0; i < blk_cnt; i++) begin
        if (payload_addr(i) != item.pointer_in) continue;
        res.status = ST_OK;
        if (blk_avail[i]) break;
        blk_avail[i] = 1'b1;
        if (i + 1 < blk_cnt && blk_avail[i + 1]) begin
          blk_len[i] = blk_len[i] + SIZE_W'(HDR) + blk_len[i + 1];
          drop_entry(i + 1);
        end
        if (i > 0 && blk_avail[i - 1]) begin
          blk_len[i - 1] = blk_len[i - 1] + SIZE_W'(HDR) + blk_len[i];
          drop_entry(i);
        end
        break;
      end
    end
    return res;
  endfunction

  assign pending = expected_rsp.size();

  initial begin
    fail_count = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      arena_base = '0;
      arena_size = SIZE_W'(65536);
      table_clear();
      expected_rsp.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $error("unexpected result item: address %h status %0d",
                 rsp.data.address, rsp.data.status);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.data.address !== want.address) begin
            $error("address: expected %h, actual %h", want.address, rsp.data.address);
            fail_count++;
          end
          if (rsp.data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.data.status);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_BASE) arena_base = cfg_data[ADDR_W-1:0];
        else arena_size = cfg_data[SIZE_W-1:0];
        table_clear();
      end
      if (req.valid && req.ready) expected_rsp.push_back(heap_op(req.data));
    end
  end
endmodule

### verif/first_fit_heap_allocator_unit_tb.sv
module first_fit_heap_allocator_unit_tb;
  import ffha_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  int                   sent;
  int                   received;
  bit                   no_idle;
  logic [ADDR_W-1:0]    live_ptrs[$];
  logic [SIZE_W-1:0]    cur_size;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  ffha_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // Valid stays high across back-to-back items; it drops only for a gap or a drain.
  task automatic send_item(logic op, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] ptr);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= '{opcode: op, request_size: size, pointer_in: ptr};
    do @(posedge clk); while (!req.ready);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (received != sent) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == REG_HEAP_SIZE) cur_size = value[SIZE_W-1:0];
    live_ptrs.delete();
  endtask

  task automatic set_arena(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size);
    drain();
    write_reg(REG_HEAP_BASE, CFG_W'(base));
    write_reg(REG_HEAP_SIZE, CFG_W'(size));
    cfg_we <= 1'b0;
  endtask

  task automatic free_live(bit keep);
    int idx;
    logic [ADDR_W-1:0] p;
    if (live_ptrs.size() == 0) begin
      send_item(OP_FREE, $urandom, '0);
    end else begin
      idx = $urandom_range(0, live_ptrs.size() - 1);
      p = live_ptrs[idx];
      if (!keep) live_ptrs.delete(idx);
      send_item(OP_FREE, $urandom, p);
    end
  endtask

  task automatic random_item();
    int pick;
    logic [ADDR_W-1:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_item(OP_ALLOC, '0, ADDR_W'({$urandom, $urandom}));
    end else if (pick < 10) begin
      send_item(OP_ALLOC, $urandom, ADDR_W'({$urandom, $urandom}));
    end else if (pick < 15) begin
      send_item(OP_ALLOC, $urandom_range(1, cur_size), ADDR_W'({$urandom, $urandom}));
    end else if (pick < 50) begin
      send_item(OP_ALLOC, $urandom_range(1, cur_size / 32 + 1),
                ADDR_W'({$urandom, $urandom}));
    end else if (pick < 85) begin
      free_live($urandom_range(0, 4) == 0);
    end else if (pick < 90) begin
      send_item(OP_FREE, $urandom, '0);
    end else if (pick < 95 || live_ptrs.size() == 0) begin
      p = ADDR_W'({$urandom, $urandom});
      send_item(OP_FREE, $urandom, p);
    end else begin
      p = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)] + ADDR_W'(8);
      send_item(OP_FREE, $urandom, p);
    end
  endtask

  // Result side: collects granted addresses so that frees can name real blocks.
  initial begin
    int gap;
    rsp.ready = 1'b0;
    received = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      if (rsp.data.address != '0) live_ptrs.push_back(rsp.data.address);
      received++;
    end
  end

  initial begin
    logic [ADDR_W-1:0] p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.data = '0;
    sent = 0;
    no_idle = 1'b0;
    cur_size = SIZE_W'(65536);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset arena.
    send_item(OP_ALLOC, '0, '0);
    send_item(OP_ALLOC, 32'd1, '0);
    send_item(OP_ALLOC, 32'd16, '0);
    send_item(OP_ALLOC, 32'd17, '0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(OP_FREE, 32'hFFFF_FFFF, '0);
    send_item(OP_FREE, '0, 48'hFFFF_FFFF_FFFF);
    drain();
    p = live_ptrs[1];
    send_item(OP_FREE, '0, p);
    send_item(OP_FREE, '0, p);
    send_item(OP_FREE, '0, live_ptrs[2]);
    send_item(OP_FREE, '0, live_ptrs[0]);
    send_item(OP_ALLOC, 32'd65512, '0);
    send_item(OP_FREE, '0, p + ADDR_W'(1));

    // Payload addresses wrap past the top of the address space.
    set_arena(48'hFFFF_FFFF_FFF0, SIZE_W'(64));
    send_item(OP_ALLOC, 32'd16, '0);
    send_item(OP_ALLOC, 32'd1, '0);
    send_item(OP_FREE, '0, 48'h8);
    send_item(OP_FREE, '0, 48'h8);

    // An arena smaller than one header holds a single empty block.
    set_arena(48'h1000, SIZE_W'(20));
    send_item(OP_ALLOC, 32'd1, '0);
    send_item(OP_FREE, '0, 48'h1018);
    send_item(OP_ALLOC, 32'd16, '0);

    // Pack many small blocks back to back, then free some of them.
    no_idle = 1'b1;
    set_arena('0, SIZE_W'(65536));
    repeat (100) send_item(OP_ALLOC, 32'd16, '0);
    send_item(OP_ALLOC, 32'd1, '0);
    drain();
    no_idle = 1'b0;
    repeat (20) free_live(1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_arena(ADDR_W'({$urandom, $urandom}), SIZE_W'(1048576));
        1: set_arena('0, SIZE_W'(64));
        2: set_arena(48'hFFFF_FFFF_FFFF, SIZE_W'(4096));
        3: set_arena(ADDR_W'({$urandom, $urandom}), SIZE_W'($urandom_range(64, 1048576)));
        4: set_arena(ADDR_W'({$urandom, $urandom}), SIZE_W'(2097151));
        default: set_arena(ADDR_W'({$urandom, $urandom}), SIZE_W'($urandom_range(64, 8192)));
      endcase
      no_idle = (ph == 2);
      repeat (72) random_item();
    end
    no_idle = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_if.sv
rtl/core/first_fit_heap_allocator_unit.sv
verif/ffha_checker.sv
verif/first_fit_heap_allocator_unit_tb.sv
